// ===== sv/sha_pkg.sv =====
// shared types, constants and functions for the sha-256 byte stream hasher
package sha_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       last;
    } sha_in_t;

    typedef struct packed {
        logic [63:0] digest_part_0;
        logic [63:0] digest_part_1;
        logic [63:0] digest_part_2;
        logic [63:0] digest_part_3;
    } sha_out_t;

    // start request from the front end to the round engine
    typedef struct packed {
        logic start;
        logic final_blk;
    } sha_ctl_t;

    localparam int BlockWords = 16;
    localparam int Rounds     = 64;

    localparam logic [7:0] PadByte = 8'h80;

    localparam logic [31:0] InitHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== sv/sha256_byte_stream_hasher.sv =====
// sha-256 byte stream hasher, 64 rounds per 64-byte block
// the digest follows the last transfer after one final block, or after two when padding and length overflow
// throughput: one byte per cycle inside a block; a full block stalls input while the engine runs
// the 64-round engine and the single block buffer set the sustained rate
// reset: asynchronous active low, chaining words reload the initial hash values
module sha256_byte_stream_hasher
    import sha_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  sha_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output sha_out_t out_data
);

    sha_ctl_t    ctl;
    logic        buf_busy, eng_busy, dig_valid;
    logic [3:0]  rd_addr;
    logic [31:0] rd_data;
    sha_out_t    dig;
    logic        in_take;

    assign in_ready = !buf_busy && !eng_busy && !out_valid;
    assign in_take  = in_valid && in_ready;

    sha_block_buf u_buf (
        .clk, .rst_n, .in_item(in_data), .in_take, .eng_busy,
        .rd_addr, .rd_data, .ctl, .busy(buf_busy)
    );

    sha_round_eng u_eng (
        .clk, .rst_n, .ctl, .blk_addr(rd_addr), .blk_data(rd_data),
        .busy(eng_busy), .dig_valid, .dig
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (dig_valid)
            out_valid <= 1'b1;
        else if (out_ready)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (dig_valid)
            out_data <= dig;
    end

endmodule

// ===== sv/sha_block_buf.sv =====
// block buffer: byte assembly, padding and length, word memory read port
module sha_block_buf
    import sha_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  sha_in_t  in_item,
    input  logic     in_take,
    input  logic     eng_busy,
    input  logic [3:0] rd_addr,
    output logic [31:0] rd_data,
    output sha_ctl_t ctl,
    output logic     busy
);

    typedef enum logic [3:0] {
        S_FILL = 4'b0001,
        S_PAD  = 4'b0010,
        S_WAIT = 4'b0100,
        S_LEN  = 4'b1000
    } buf_state_t;

    logic [31:0] mem [BlockWords];
    logic [63:0] count_reg, count_next;
    logic [31:0] word_reg, word_next;
    buf_state_t  state_reg, state_next;
    logic [3:0]  pad_idx_reg, pad_idx_next;
    logic        wr_en;
    logic [3:0]  wr_addr;
    logic [31:0] wr_data;
    logic [63:0] bits;
    logic [1:0]  bsel;
    logic [31:0] pad_word;

    assign bits = {count_reg[60:0], 3'b000};
    assign bsel = count_reg[1:0];
    assign busy = (state_reg != S_FILL);

    always_comb
    begin
        unique case (bsel)
            2'd0: pad_word = {PadByte, 24'h0};
            2'd1: pad_word = {word_reg[7:0], PadByte, 16'h0};
            2'd2: pad_word = {word_reg[15:0], PadByte, 8'h0};
            default: pad_word = {word_reg[23:0], PadByte};
        endcase
    end

    always_comb
    begin
        count_next   = count_reg;
        word_next    = word_reg;
        state_next   = state_reg;
        pad_idx_next = pad_idx_reg;
        wr_en        = 1'b0;
        wr_addr      = count_reg[5:2];
        wr_data      = '0;
        ctl          = '0;
        unique case (state_reg)
            S_FILL:
            begin
                if (in_take && in_item.byte_present)
                begin
                    word_next = {word_reg[23:0], in_item.data_byte};
                    count_next = count_reg + 64'd1;
                    if (bsel == 2'd3)
                    begin
                        wr_en   = 1'b1;
                        wr_data = {word_reg[23:0], in_item.data_byte};
                    end
                    if (count_reg[5:0] == 6'd63)
                    begin
                        ctl.start = 1'b1;
                        state_next = in_item.last ? S_PAD : S_WAIT;
                    end
                end
                if (in_take && in_item.last && !(in_item.byte_present
                        && count_reg[5:0] == 6'd63))
                    state_next = S_PAD;
                pad_idx_next = in_item.byte_present ? count_next[5:2] : count_reg[5:2];
            end
            S_PAD:
            begin
                if (!eng_busy)
                begin
                    wr_en   = 1'b1;
                    wr_addr = pad_idx_reg;
                    wr_data = (pad_idx_reg == count_reg[5:2]) ? pad_word : 32'h0;
                    if (pad_idx_reg == 4'd13 && count_reg[5:0] < 6'd56)
                        state_next = S_LEN;
                    else if (pad_idx_reg == 4'd15)
                    begin
                        ctl.start  = 1'b1;
                        state_next = S_LEN;
                    end
                    pad_idx_next = pad_idx_reg + 4'd1;
                end
            end
            S_LEN:
            begin
                if (!eng_busy)
                begin
                    wr_en   = 1'b1;
                    wr_addr = pad_idx_reg;
                    if (pad_idx_reg == 4'd14)
                        wr_data = bits[63:32];
                    else if (pad_idx_reg == 4'd15)
                        wr_data = bits[31:0];
                    else
                        wr_data = 32'h0;
                    pad_idx_next = pad_idx_reg + 4'd1;
                    if (pad_idx_reg == 4'd15)
                    begin
                        ctl.start     = 1'b1;
                        ctl.final_blk = 1'b1;
                        count_next    = '0;
                        state_next    = S_WAIT;
                    end
                end
            end
            default:
            begin
                if (!eng_busy)
                    state_next = S_FILL;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_FILL;
            count_reg   <= '0;
            pad_idx_reg <= '0;
            word_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pad_idx_reg <= pad_idx_next;
            word_reg    <= word_next;
        end
    end

endmodule

// ===== sv/sha_round_eng.sv =====
// round engine: schedule memory, working variables, chaining words
module sha_round_eng
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  sha_ctl_t    ctl,
    output logic [3:0]  blk_addr,
    input  logic [31:0] blk_data,
    output logic        busy,
    output logic        dig_valid,
    output sha_out_t    dig
);

    typedef enum logic [3:0] {
        E_IDLE  = 4'b0001,
        E_PRIME = 4'b0010,
        E_ROUND = 4'b0100,
        E_ADD   = 4'b1000
    } eng_state_t;

    eng_state_t  state_reg, state_next;
    logic [6:0]  rnd_reg, rnd_next;
    logic        final_reg;
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [31:0] w_cur, s0, s1, big0, big1, ch, maj, t1;
    logic [5:0]  r6;

    // schedule window kept as shift taps, each read at a fixed place
    assign r6 = rnd_reg[5:0];
    assign blk_addr = (state_reg == E_ROUND) ? r6[3:0] + 4'd1 : 4'd0;
    assign busy = (state_reg != E_IDLE);

    always_comb
    begin
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_cur = (r6 < 6'd16) ? blk_data : (w_reg[0] + s0 + w_reg[9] + s1);
        big1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1   = v_reg[7] + big1 + ch + RoundK[r6] + w_cur;
        big0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        maj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    end

    always_comb
    begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        unique case (state_reg)
            E_IDLE:  if (ctl.start) state_next = E_PRIME;
            E_PRIME: begin state_next = E_ROUND; rnd_next = '0; end
            E_ROUND:
            begin
                rnd_next = rnd_reg + 7'd1;
                if (rnd_reg == 7'(Rounds - 1))
                    state_next = E_ADD;
            end
            default: state_next = E_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == E_ROUND)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= w_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            rnd_reg   <= '0;
            final_reg <= 1'b0;
            dig_valid <= 1'b0;
            dig       <= '0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= InitHash[i];
                v_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            dig_valid <= 1'b0;
            if (state_reg == E_IDLE && ctl.start)
                final_reg <= ctl.final_blk;
            if (state_reg == E_PRIME)
                for (int i = 0; i < 8; i++)
                    v_reg[i] <= h_reg[i];
            if (state_reg == E_ROUND)
            begin
                v_reg[7] <= v_reg[6];
                v_reg[6] <= v_reg[5];
                v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2];
                v_reg[2] <= v_reg[1];
                v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + big0 + maj;
            end
            if (state_reg == E_ADD)
            begin
                if (final_reg)
                begin
                    dig_valid <= 1'b1;
                    dig <= {h_reg[0] + v_reg[0], h_reg[1] + v_reg[1],
                            h_reg[2] + v_reg[2], h_reg[3] + v_reg[3],
                            h_reg[4] + v_reg[4], h_reg[5] + v_reg[5],
                            h_reg[6] + v_reg[6], h_reg[7] + v_reg[7]};
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= InitHash[i];
                end
                else
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= h_reg[i] + v_reg[i];
            end
        end
    end

endmodule

// ===== sv/sha_checker.sv =====
// port-level checker for the sha-256 hasher
module sha_checker
    import sha_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_ready,
    input logic     out_valid,
    input logic     out_ready,
    input sha_out_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("digest dropped or changed while stalled");

    a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while digest pending");

    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("digest appeared while input was open");

endmodule

bind sha256_byte_stream_hasher sha_checker u_chk (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
